### rtl/mmbp_pkg.sv
`default_nettype none
package mmbp_pkg;

  typedef enum logic [1:0] {
    MODE_STATIC  = 2'd0,
    MODE_GSHARE  = 2'd1,
    MODE_TOURN   = 2'd2,
    MODE_CUSTOM  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_MODE = 2'd0,
    REG_GHB  = 2'd1,
    REG_LHB  = 2'd2,
    REG_PCB  = 2'd3
  } reg_idx_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 4;
  localparam int unsigned PcW      = 32;
  localparam int unsigned GhistW   = 13;
  localparam int unsigned LhistW   = 8;
  localparam int unsigned PcIdxMax = 11;
  localparam logic [1:0]  CtrInit  = 2'd1;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_WRITE = 4'b1000
  } state_e;

  // Two-bit saturating counter step.
  function automatic logic [1:0] bump(input logic [1:0] c, input logic t);
    logic [1:0] r;
    r = c;
    if (t && c != 2'd3) r = c + 2'd1;
    if (!t && c != 2'd0) r = c - 2'd1;
    return r;
  endfunction

  // Clamp a width register to 1..hi.
  function automatic logic [3:0] clampw(input logic [3:0] v, input logic [3:0] hi);
    logic [3:0] r;
    r = v;
    if (v == 4'd0) r = 4'd1;
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/mmbp_if.sv
`default_nettype none
interface mmbp_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] pc;
  logic        outcome;
  modport source (output valid, cmd, pc, outcome, input ready);
  modport sink (input valid, cmd, pc, outcome, output ready);
endinterface

interface mmbp_rsp_if;
  logic valid;
  logic ready;
  logic taken;
  modport source (output valid, taken, input ready);
  modport sink (input valid, taken, output ready);
endinterface
`default_nettype wire

### rtl/multi_mode_branch_predictor.sv
// Multi-mode branch predictor (static, gshare, tournament, tiered).
// Requests arrive on req (cmd, pc, outcome): cmd 0 asks for a prediction and
// yields one word on rsp (taken); cmd 1 trains and yields nothing.
// A request passes through accept, a read phase of table reads from the
// synchronous RAMs, then a write-back step: a predict registers its answer,
// a train writes the updated counters back. A predict in tournament or tiered
// mode needs a second read phase, because the local counter address depends
// on the local history just read. A new request is accepted only once the
// previous one has left its write-back step, so the block cannot take a new
// request before it is through with the last one.
// The answer is held in an output register; a predict waits in its
// write-back step while a previous answer has not been taken.
// After reset the block sweeps all tables to their initial values, one
// entry per cycle, for the depth of the largest table (8192 entries by
// default); req.ready stays low meanwhile. Configuration writes
// on cfg_we_i/cfg_idx_i/cfg_data_i are taken at any time and should only
// be made while the block is idle.
`default_nettype none
module multi_mode_branch_predictor
  import mmbp_pkg::*;
#(
  parameter int unsigned GLOBAL_TABLE_DEPTH = 8192,
  parameter int unsigned LOCAL_TABLE_DEPTH  = 2048,
  parameter int unsigned BIMODAL_INDEX_BITS = 9
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  mmbp_req_if.sink                 req,
  mmbp_rsp_if.source               rsp
);
  localparam int unsigned GW = $clog2(GLOBAL_TABLE_DEPTH);
  localparam int unsigned LW = $clog2(LOCAL_TABLE_DEPTH);
  localparam int unsigned BW = BIMODAL_INDEX_BITS;
  localparam int unsigned BD = 1 << BW;
  localparam int unsigned CW = (GW > LW) ? ((GW > BW) ? GW : BW) : ((LW > BW) ? LW : BW);
  localparam int unsigned ClrLast = ((GLOBAL_TABLE_DEPTH > LOCAL_TABLE_DEPTH) ?
      ((GLOBAL_TABLE_DEPTH > BD) ? GLOBAL_TABLE_DEPTH : BD) :
      ((LOCAL_TABLE_DEPTH > BD) ? LOCAL_TABLE_DEPTH : BD)) - 1;

  // Configuration registers.
  logic [1:0] mode_q;
  logic [3:0] ghb_q, lhb_q, pcb_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_STATIC;
      ghb_q  <= 4'd13;
      lhb_q  <= 4'd8;
      pcb_q  <= 4'd10;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_MODE: mode_q <= cfg_data_i[1:0];
        REG_GHB:  ghb_q  <= cfg_data_i;
        REG_LHB:  lhb_q  <= cfg_data_i;
        REG_PCB:  pcb_q  <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // Effective masks.
  logic [GhistW-1:0] gmask;
  logic [LhistW-1:0] lmask;
  logic [PcIdxMax-1:0] pmask;
  assign gmask = GhistW'((32'd1 << clampw(ghb_q, 4'd13)) - 32'd1);
  assign lmask = LhistW'((32'd1 << clampw(lhb_q, 4'd8)) - 32'd1);
  assign pmask = PcIdxMax'((32'd1 << clampw(pcb_q, 4'd11)) - 32'd1);

  state_e state_q, state_d;
  logic [CW-1:0] clr_q;
  logic          cmd_q, out_q;
  logic [29:0]   word_q;
  logic [GhistW-1:0] ghist_q;
  logic [LhistW-1:0] cap_q;
  logic rv_q;
  logic rtaken_q;

  // Table addresses, from the latched word and history.
  logic [31:0] wtier, wgsh, wbr;
  logic [GW-1:0] gs_a, ti_a;
  logic [LW-1:0] br_a, lc_a_pred, lc_a_train;
  logic [BW-1:0] bi_a;
  assign wtier = {19'd0, word_q[GhistW-1:0] & gmask};
  assign wgsh  = {19'd0, (word_q[GhistW-1:0] ^ ghist_q) & gmask};
  assign wbr   = {21'd0, word_q[PcIdxMax-1:0] & pmask};
  assign ti_a = GW'(wtier % GLOBAL_TABLE_DEPTH);
  assign gs_a = GW'(wgsh % GLOBAL_TABLE_DEPTH);
  assign br_a = LW'(wbr % LOCAL_TABLE_DEPTH);
  assign bi_a = word_q[BW-1:0];
  assign lc_a_train = LW'((wbr ^ {24'd0, cap_q}) % LOCAL_TABLE_DEPTH);

  // Read data.
  logic [1:0] gs_rd, lc_rd, ch_rd, bm_rd;
  logic [2:0] ti_rd;
  logic [LhistW-1:0] lh_rd;
  logic [LhistW-1:0] cap_new;
  assign cap_new = lh_rd & lmask;
  assign lc_a_pred = LW'((wbr ^ {24'd0, cap_new}) % LOCAL_TABLE_DEPTH);

  // The local counter read depends on the local history read, so a predict
  // in a local mode needs a second read phase: handled with an extra phase.
  logic phase_q;
  logic local_pred;
  assign local_pred = !cmd_q && (mode_q == MODE_TOURN || mode_q == MODE_CUSTOM);

  logic clearing;
  assign clearing = (state_q == ST_CLEAR);

  // Write enables and data.
  logic gs_we, lh_we, lc_we, ch_we, bm_we, ti_we;
  logic [1:0] gs_wd, lc_wd, ch_wd, bm_wd;
  logic [2:0] ti_wd;
  logic [LhistW-1:0] lh_wd;
  logic ghist_upd;
  logic gok, lok;
  logic pred;
  logic do_write;
  assign do_write = (state_q == ST_WRITE) && !(rv_q && !rsp.ready && !cmd_q);

  always_comb begin
    gs_we = 1'b0; lh_we = 1'b0; lc_we = 1'b0; ch_we = 1'b0; bm_we = 1'b0; ti_we = 1'b0;
    gs_wd = bump(gs_rd, out_q);
    lc_wd = bump(lc_rd, out_q);
    bm_wd = bump(bm_rd, out_q);
    ch_wd = ch_rd;
    ti_wd = ti_rd;
    lh_wd = LhistW'({cap_q, out_q});
    ghist_upd = 1'b0;
    gok = (gs_rd[1] == out_q);
    lok = (lc_rd[1] == out_q);
    pred = 1'b1;
    unique case (mode_e'(mode_q))
      MODE_GSHARE: pred = gs_rd[1];
      MODE_TOURN:  pred = ch_rd[1] ? lc_rd[1] : gs_rd[1];
      MODE_CUSTOM: pred = (ti_rd <= 3'd2) ? bm_rd[1] : ((ti_rd <= 3'd6) ? lc_rd[1] : gs_rd[1]);
      default:     pred = 1'b1;
    endcase
    if (do_write && cmd_q) begin
      unique case (mode_e'(mode_q))
        MODE_GSHARE: begin gs_we = 1'b1; ghist_upd = 1'b1; end
        MODE_TOURN: begin
          gs_we = 1'b1; lc_we = 1'b1; lh_we = 1'b1; ghist_upd = 1'b1;
          if (lok && !gok) begin ch_we = 1'b1; ch_wd = bump(ch_rd, 1'b1); end
          else if (gok && !lok) begin ch_we = 1'b1; ch_wd = bump(ch_rd, 1'b0); end
        end
        MODE_CUSTOM: begin
          if (ti_rd <= 3'd2) begin
            bm_we = 1'b1;
            if (bm_rd[1] != out_q) begin ti_we = 1'b1; ti_wd = ti_rd + 3'd1; end
          end else if (ti_rd <= 3'd6) begin
            lc_we = 1'b1; lh_we = 1'b1;
            if (!lok) begin ti_we = 1'b1; ti_wd = ti_rd + 3'd1; end
            else if (ti_rd > 3'd3) begin ti_we = 1'b1; ti_wd = ti_rd - 3'd1; end
          end else begin
            gs_we = 1'b1; ghist_upd = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (clearing) begin
      gs_we = 1'b1; lh_we = 1'b1; lc_we = 1'b1; ch_we = 1'b1; bm_we = 1'b1; ti_we = 1'b1;
      gs_wd = CtrInit; lc_wd = CtrInit; ch_wd = CtrInit; bm_wd = CtrInit;
      ti_wd = 3'd0; lh_wd = '0;
    end
  end

  // Addresses muxed with the clearing sweep.
  logic [GW-1:0] gs_wa, ti_wa;
  logic [LW-1:0] lh_wa, lc_wa, ch_wa, lc_ra;
  logic [BW-1:0] bm_wa;
  assign gs_wa = clearing ? clr_q[GW-1:0] : gs_a;
  assign ti_wa = clearing ? clr_q[GW-1:0] : ti_a;
  assign lh_wa = clearing ? clr_q[LW-1:0] : br_a;
  assign ch_wa = clearing ? clr_q[LW-1:0] : br_a;
  assign lc_wa = clearing ? clr_q[LW-1:0] : lc_a_train;
  assign bm_wa = clearing ? clr_q[BW-1:0] : bi_a;
  assign lc_ra = cmd_q ? lc_a_train : lc_a_pred;

  logic gs_w, lh_w, lc_w, ch_w, bm_w, ti_w;
  assign gs_w = gs_we && (!clearing || clr_q <= CW'(GLOBAL_TABLE_DEPTH - 1));
  assign lh_w = lh_we && (!clearing || clr_q <= CW'(LOCAL_TABLE_DEPTH - 1));
  assign lc_w = lc_we && (!clearing || clr_q <= CW'(LOCAL_TABLE_DEPTH - 1));
  assign ch_w = ch_we && (!clearing || clr_q <= CW'(LOCAL_TABLE_DEPTH - 1));
  assign bm_w = bm_we && (!clearing || clr_q <= CW'(BD - 1));
  assign ti_w = ti_we && (!clearing || clr_q <= CW'(GLOBAL_TABLE_DEPTH - 1));

  mmbp_ram #(.Width(2), .Depth(GLOBAL_TABLE_DEPTH)) u_gshare (
    .clk_i, .we_i(gs_w), .waddr_i(gs_wa), .wdata_i(gs_wd), .raddr_i(gs_a), .rdata_o(gs_rd));
  mmbp_ram #(.Width(3), .Depth(GLOBAL_TABLE_DEPTH)) u_tier (
    .clk_i, .we_i(ti_w), .waddr_i(ti_wa), .wdata_i(ti_wd), .raddr_i(ti_a), .rdata_o(ti_rd));
  mmbp_ram #(.Width(LhistW), .Depth(LOCAL_TABLE_DEPTH)) u_lhist (
    .clk_i, .we_i(lh_w), .waddr_i(lh_wa), .wdata_i(lh_wd), .raddr_i(br_a), .rdata_o(lh_rd));
  mmbp_ram #(.Width(2), .Depth(LOCAL_TABLE_DEPTH)) u_local (
    .clk_i, .we_i(lc_w), .waddr_i(lc_wa), .wdata_i(lc_wd), .raddr_i(lc_ra), .rdata_o(lc_rd));
  mmbp_ram #(.Width(2), .Depth(LOCAL_TABLE_DEPTH)) u_chooser (
    .clk_i, .we_i(ch_w), .waddr_i(ch_wa), .wdata_i(ch_wd), .raddr_i(br_a), .rdata_o(ch_rd));
  mmbp_ram #(.Width(2), .Depth(BD)) u_bimodal (
    .clk_i, .we_i(bm_w), .waddr_i(bm_wa), .wdata_i(bm_wd), .raddr_i(bi_a), .rdata_o(bm_rd));

  // Sequencer: clear, idle, read (one phase, or two for a local predict), write back.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == CW'(ClrLast)) state_d = ST_IDLE;
      ST_IDLE:  if (req.valid) state_d = ST_READ;
      ST_READ:  if (!local_pred || phase_q) state_d = ST_WRITE;
      ST_WRITE: if (do_write) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  assign req.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      ghist_q  <= '0;
      cap_q    <= '0;
      phase_q  <= 1'b0;
      rv_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clearing) clr_q <= clr_q + CW'(1);
      if (state_q == ST_READ) phase_q <= local_pred && !phase_q;
      // Capture the local history once its read has completed, in the second
      // read phase of a local predict.
      if (state_q == ST_READ && local_pred && phase_q) cap_q <= cap_new;
      if (ghist_upd) ghist_q <= {ghist_q[GhistW-2:0], out_q};
      if (do_write && !cmd_q) rv_q <= 1'b1;
      else if (rsp.ready) rv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      cmd_q  <= req.cmd;
      word_q <= req.pc[PcW-1:2];
      out_q  <= req.outcome;
    end
    if (do_write && !cmd_q) rtaken_q <= pred;
  end

  assign rsp.valid = rv_q;
  assign rsp.taken = rtaken_q;

  // No request is taken during the clearing sweep.
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !req.ready) else $error("accept during clear");
  // A train never raises a response.
  a_train_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_write && cmd_q && !rv_q) |=> !rv_q) else $error("train answered");
  // Write-back never overruns a pending response.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_write && !cmd_q) |-> (!rv_q || rsp.ready)) else $error("response overrun");
endmodule
`default_nettype wire

### rtl/mmbp_ram.sv
`default_nettype none
module mmbp_ram #(
  parameter int unsigned Width = 2,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire
